// ===== hw/rtl/cpfm_pkg.sv =====
`timescale 1ns / 1ps

package cpfm_pkg;

  localparam int CAP_W = 16;
  localparam int COUNTER_BITS = 16;
  localparam int CLK_W = 28;
  localparam int DIV_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W = $clog2(CLK_W);

  localparam logic [CLK_W-1:0] TIMER_CLOCK_RST = CLK_W'(16000000);
  localparam logic [DIV_W-1:0] PRESCALE_RST = DIV_W'(1679);
  localparam logic [CLK_W-1:0] REPORT_LIMIT_RST = CLK_W'(50);

  localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_LIMIT = CFG_IDX_W'(2);

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_NO_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_RATE,
    ST_DIV_FREQ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/cpfm_div.sv =====
`timescale 1ns / 1ps

module cpfm_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [cpfm_pkg::CLK_W-1:0]      dividend,
  input  logic [cpfm_pkg::DIV_W-1:0]      divisor,
  output cpfm_pkg::div_stat_t             stat,
  output logic [cpfm_pkg::CLK_W-1:0]      quotient
);

  localparam logic [cpfm_pkg::STEP_W-1:0] LAST_STEP = cpfm_pkg::STEP_W'(cpfm_pkg::CLK_W - 1);

  logic [cpfm_pkg::CLK_W-1:0]  quo_r, quo_nxt;
  logic [cpfm_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [cpfm_pkg::DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [cpfm_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [cpfm_pkg::DIV_W:0]    trial;
  logic [cpfm_pkg::DIV_W:0]    diff;
  logic                        fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[cpfm_pkg::CLK_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[cpfm_pkg::CLK_W-2:0], fits};
      rem_nxt  = fits ? diff[cpfm_pkg::DIV_W-1:0] : trial[cpfm_pkg::DIV_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== hw/rtl/capture_pair_frequency_meter.sv =====
`timescale 1ns / 1ps

// Frequency meter over pairs of 16-bit capture timestamps. The first capture of
// a pair is stored and returns nothing; the second returns frequency =
// (timer_clock / prescale_divisor) / period, period taken modulo 2^16, with a
// within_limit flag for frequency <= report_limit. Equal captures return status
// 1 and frequency 0. A second capture runs two 28-bit divisions on one shared
// bit-serial divider at one quotient bit per cycle, then waits in the result
// state while the output is stalled. Input is taken again as soon as the result
// is loaded into the output register. Prescale divisor 0 acts as 1. The user
// must write configuration only while the block is idle; it is not enforced.

module capture_pair_frequency_meter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cpfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpfm_pkg::CLK_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cpfm_pkg::CAP_W-1:0]        in_capture_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cpfm_pkg::CLK_W-1:0]        out_frequency,
  output logic                              out_status,
  output logic                              out_within_limit
);

  cpfm_pkg::state_t state_r, state_nxt;

  logic [cpfm_pkg::CLK_W-1:0]        timer_clock_r;
  logic [cpfm_pkg::DIV_W-1:0]        prescale_r;
  logic [cpfm_pkg::CLK_W-1:0]        report_limit_r;
  logic                              phase_r, phase_nxt;
  logic [cpfm_pkg::COUNTER_BITS-1:0] first_r, first_nxt;
  logic [cpfm_pkg::COUNTER_BITS-1:0] period_r, period_nxt;
  logic                              err_r, err_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [cpfm_pkg::CLK_W-1:0]        out_freq_r, out_freq_nxt;
  logic                              out_status_r, out_status_nxt;
  logic                              out_within_r, out_within_nxt;
  logic [cpfm_pkg::COUNTER_BITS-1:0] cap;
  logic [cpfm_pkg::COUNTER_BITS-1:0] period_new;
  logic                              in_accept;
  logic                              div_start;
  logic [cpfm_pkg::CLK_W-1:0]        div_dividend;
  logic [cpfm_pkg::DIV_W-1:0]        div_divisor;
  cpfm_pkg::div_stat_t               div_stat;
  logic [cpfm_pkg::CLK_W-1:0]        div_quotient;

  assign cap        = in_capture_value[cpfm_pkg::COUNTER_BITS-1:0];
  assign period_new = cap - first_r;
  assign in_stall   = (state_r != cpfm_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_clock_r  <= cpfm_pkg::TIMER_CLOCK_RST;
      prescale_r     <= cpfm_pkg::PRESCALE_RST;
      report_limit_r <= cpfm_pkg::REPORT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cpfm_pkg::REG_TIMER_CLOCK:  timer_clock_r  <= cfg_data;
        cpfm_pkg::REG_PRESCALE:     prescale_r     <= cfg_data[cpfm_pkg::DIV_W-1:0];
        cpfm_pkg::REG_REPORT_LIMIT: report_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    first_nxt      = first_r;
    period_nxt     = period_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_freq_nxt   = out_freq_r;
    out_status_nxt = out_status_r;
    out_within_nxt = out_within_r;
    div_start      = 1'b0;
    div_dividend   = timer_clock_r;
    div_divisor    = (prescale_r == '0) ? cpfm_pkg::DIV_W'(1) : prescale_r;
    case (state_r)
      cpfm_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (!phase_r) begin
            first_nxt = cap;
            phase_nxt = 1'b1;
          end else begin
            phase_nxt  = 1'b0;
            period_nxt = period_new;
            if (period_new == '0) begin
              err_nxt   = 1'b1;
              state_nxt = cpfm_pkg::ST_RESULT;
            end else begin
              err_nxt   = 1'b0;
              div_start = 1'b1;
              state_nxt = cpfm_pkg::ST_DIV_RATE;
            end
          end
        end
      end
      cpfm_pkg::ST_DIV_RATE: begin
        if (div_stat.done) begin
          div_start    = 1'b1;
          div_dividend = div_quotient;
          div_divisor  = period_r;
          state_nxt    = cpfm_pkg::ST_DIV_FREQ;
        end
      end
      cpfm_pkg::ST_DIV_FREQ: begin
        if (div_stat.done) begin
          state_nxt = cpfm_pkg::ST_RESULT;
        end
      end
      cpfm_pkg::ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_freq_nxt   = '0;
            out_status_nxt = cpfm_pkg::STATUS_NO_PERIOD;
            out_within_nxt = 1'b0;
          end else begin
            out_freq_nxt   = div_quotient;
            out_status_nxt = cpfm_pkg::STATUS_OK;
            out_within_nxt = (div_quotient <= report_limit_r);
          end
          state_nxt = cpfm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cpfm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpfm_pkg::ST_IDLE;
      phase_r     <= 1'b0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    period_r     <= period_nxt;
    err_r        <= err_nxt;
    out_freq_r   <= out_freq_nxt;
    out_status_r <= out_status_nxt;
    out_within_r <= out_within_nxt;
  end

  cpfm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  assign out_valid        = out_valid_r;
  assign out_frequency    = out_freq_r;
  assign out_status       = out_status_r;
  assign out_within_limit = out_within_r;

endmodule
